>>> src/quaternion_to_euler_angles_assert.svh
// Assertion macros for the quaternion to Euler angle converter.
// Included by the top level; no other dependencies.
`ifndef QUATERNION_TO_EULER_ANGLES_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_ASSERT_SVH
`ifndef SYNTHESIS
`define QTE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define QTE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define QTE_ASSERT(lbl, clk, rstn, prop)
`define QTE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> src/qte_pkg.sv
// Shared types, widths and the CORDIC angle table for the converter.
// No dependencies.
package qte_pkg;
  localparam int AW = 34;
  localparam int CW = 37;
  localparam int ZW = 24;
  localparam int RW = 57;
  localparam int SW = 29;
  localparam int HALF_PI_Q20 = 1647099;
  localparam int PI_Q13 = 25736;
  localparam int HALF_PI_Q13 = 12868;

  typedef struct packed {
    logic signed [AW-1:0] sr;
    logic signed [AW-1:0] cr;
    logic signed [AW-1:0] sy;
    logic signed [AW-1:0] cy;
    logic signed [AW-1:0] sp;
    logic                 clamp;
  } side_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
    logic [1:0]           tag;
  } cordic_t;

  function automatic logic signed [ZW-1:0] ang_tab(input logic [4:0] i);
    logic signed [ZW-1:0] a;
    unique case (i)
      5'd0:  a = 24'sd823550;
      5'd1:  a = 24'sd486170;
      5'd2:  a = 24'sd256879;
      5'd3:  a = 24'sd130396;
      5'd4:  a = 24'sd65451;
      5'd5:  a = 24'sd32757;
      5'd6:  a = 24'sd16383;
      5'd7:  a = 24'sd8192;
      5'd8:  a = 24'sd4096;
      5'd9:  a = 24'sd2048;
      5'd10: a = 24'sd1024;
      5'd11: a = 24'sd512;
      5'd12: a = 24'sd256;
      5'd13: a = 24'sd128;
      5'd14: a = 24'sd64;
      5'd15: a = 24'sd32;
      5'd16: a = 24'sd16;
      5'd17: a = 24'sd8;
      5'd18: a = 24'sd4;
      5'd19: a = 24'sd2;
      5'd20: a = 24'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction
endpackage

>>> src/qte_sqrt_cell.sv
// One result bit of the pipelined integer square root; carries side data.
// Depends on qte_pkg.
module qte_sqrt_cell #(
  parameter int BIT = 0
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [qte_pkg::RW-1:0] rem_i,
  input  logic [qte_pkg::SW-1:0] root_i,
  input  qte_pkg::side_t      side_i,
  output logic [qte_pkg::RW-1:0] rem_o,
  output logic [qte_pkg::SW-1:0] root_o,
  output qte_pkg::side_t      side_o
);
  import qte_pkg::*;

  logic [RW+1:0] trial;
  logic [RW+1:0] rem_x;
  logic          take;

  assign trial = ((RW+2)'(root_i) << (BIT + 1)) | ((RW+2)'(1) << (2 * BIT));
  assign rem_x = (RW+2)'(rem_i);
  assign take  = rem_x >= trial;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= take ? RW'(rem_x - trial) : rem_i;
      root_o <= take ? (root_i | (SW'(1) << BIT)) : root_i;
      side_o <= side_i;
    end
  end
endmodule

>>> src/qte_prerot.sv
// Quadrant pre-rotation and zero detect ahead of the CORDIC row.
// Depends on qte_pkg.
module qte_prerot (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [qte_pkg::AW-1:0] y_i,
  input  logic signed [qte_pkg::AW-1:0] x_i,
  input  logic [1:0]               tag_i,
  output qte_pkg::cordic_t         c_o
);
  import qte_pkg::*;

  logic signed [CW-1:0] xe;
  logic signed [CW-1:0] ye;
  cordic_t c_d;

  assign xe = CW'(x_i);
  assign ye = CW'(y_i);

  always_comb begin
    c_d.x    = xe;
    c_d.y    = ye;
    c_d.z    = '0;
    c_d.zero = (x_i == '0) && (y_i == '0);
    c_d.tag  = tag_i;
    if (x_i < 0) begin
      if (y_i >= 0) begin
        c_d.x = ye;
        c_d.y = -xe;
        c_d.z = ZW'(HALF_PI_Q20);
      end else begin
        c_d.x = -ye;
        c_d.y = xe;
        c_d.z = -ZW'(HALF_PI_Q20);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_o <= c_d;
    end
  end
endmodule

>>> src/qte_cordic_cell.sv
// One vectoring CORDIC micro-rotation, registered.
// Depends on qte_pkg.
module qte_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  qte_pkg::cordic_t c_i,
  output qte_pkg::cordic_t c_o
);
  import qte_pkg::*;

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [ZW-1:0] ang;
  cordic_t c_d;

  assign dx  = c_i.y >>> STEP;
  assign dy  = c_i.x >>> STEP;
  assign ang = ang_tab(5'(STEP));

  always_comb begin
    c_d = c_i;
    if (!c_i.y[CW-1]) begin
      c_d.x = c_i.x + dx;
      c_d.y = c_i.y - dy;
      c_d.z = c_i.z + ang;
    end else begin
      c_d.x = c_i.x - dx;
      c_d.y = c_i.y + dy;
      c_d.z = c_i.z - ang;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_o <= c_d;
    end
  end
endmodule

>>> src/quaternion_to_euler_angles.sv
// Quaternion (Q2.14) to roll/pitch/yaw (Q3.13) converter, top level.
// Throughput one transaction per cycle while the output is not held, set by
// the row of sqrt and CORDIC cells.
// The whole pipeline advances together; it holds while a result is not taken.
// Reset (async, active low) clears the valid bits; data registers are not reset.
// Depends on qte_pkg, the cell modules and the assertion header.
module quaternion_to_euler_angles #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,  // quat_w, quat_x, quat_y, quat_z
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,  // roll_angle, pitch_angle, yaw_angle, pad
  output logic        m_axis_tuser_o   // pitch_clamped
);
  import qte_pkg::*;

  localparam int PIPE_LEN = 34 + CORDIC_STEPS;

  logic en;
  logic accept;
  logic [PIPE_LEN-1:0] vld_q, vld_d;
  logic m_valid_q;

  assign en              = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign accept          = s_axis_tvalid_i && en;
  assign vld_d           = {vld_q[PIPE_LEN-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      m_valid_q <= 1'b0;
    end else if (en) begin
      vld_q     <= vld_d;
      m_valid_q <= vld_q[PIPE_LEN-1];
    end
  end

  // products
  logic signed [15:0] qw, qx, qy, qz;
  logic signed [31:0] wx_q, yz_q, xx_q, yy_q, wz_q, xy_q, zz_q, wy_q, zx_q;
  assign qw = $signed(s_axis_tdata_i[15:0]);
  assign qx = $signed(s_axis_tdata_i[31:16]);
  assign qy = $signed(s_axis_tdata_i[47:32]);
  assign qz = $signed(s_axis_tdata_i[63:48]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      wx_q <= qw * qx;
      yz_q <= qy * qz;
      xx_q <= qx * qx;
      yy_q <= qy * qy;
      wz_q <= qw * qz;
      xy_q <= qx * qy;
      zz_q <= qz * qz;
      wy_q <= qw * qy;
      zx_q <= qz * qx;
    end
  end

  // sums
  localparam logic signed [AW-1:0] ONE_Q28 = AW'(1) <<< 28;
  side_t side_d, side2_q, side3_q, side4_q;
  logic signed [AW-1:0] sp_d, sp_abs;
  logic [27:0] mag_q;
  logic [55:0] magsq_q;
  logic [RW-1:0] rem4_q;

  assign sp_d   = (AW'(wy_q) - AW'(zx_q)) <<< 1;
  assign sp_abs = sp_d[AW-1] ? -sp_d : sp_d;

  always_comb begin
    side_d.sr    = (AW'(wx_q) + AW'(yz_q)) <<< 1;
    side_d.cr    = ONE_Q28 - ((AW'(xx_q) + AW'(yy_q)) <<< 1);
    side_d.sy    = (AW'(wz_q) + AW'(xy_q)) <<< 1;
    side_d.cy    = ONE_Q28 - ((AW'(yy_q) + AW'(zz_q)) <<< 1);
    side_d.sp    = sp_d;
    side_d.clamp = (sp_d >= ONE_Q28) || (sp_d <= -ONE_Q28);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side2_q <= side_d;
      mag_q   <= sp_abs[27:0];
      side3_q <= side2_q;
      magsq_q <= mag_q * mag_q;
      side4_q <= side3_q;
      rem4_q  <= (RW'(1) << 56) - RW'(magsq_q);
    end
  end

  // square root row
  logic [RW-1:0] sq_rem [0:SW];
  logic [SW-1:0] sq_root [0:SW];
  side_t         sq_side [0:SW];

  assign sq_rem[0]  = rem4_q;
  assign sq_root[0] = '0;
  assign sq_side[0] = side4_q;

  for (genvar k = 0; k < SW; k++) begin : g_sqrt
    qte_sqrt_cell #(.BIT(SW - 1 - k)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .side_i (sq_side[k]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1]),
      .side_o (sq_side[k+1])
    );
  end

  // CORDIC rows: 0 roll, 1 pitch, 2 yaw
  cordic_t cr_s [0:2][0:CORDIC_STEPS];
  side_t   sf;
  assign sf = sq_side[SW];

  qte_prerot u_pre_roll (
    .clk_i (clk_i), .en_i (en), .y_i (sf.sr), .x_i (sf.cr),
    .tag_i (2'b00), .c_o (cr_s[0][0])
  );
  qte_prerot u_pre_pitch (
    .clk_i (clk_i), .en_i (en), .y_i (sf.sp), .x_i (AW'(sq_root[SW])),
    .tag_i ({sf.sp[AW-1], sf.clamp}), .c_o (cr_s[1][0])
  );
  qte_prerot u_pre_yaw (
    .clk_i (clk_i), .en_i (en), .y_i (sf.sy), .x_i (sf.cy),
    .tag_i (2'b00), .c_o (cr_s[2][0])
  );

  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_step
      qte_cordic_cell #(.STEP(s)) u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .c_i   (cr_s[ch][s]),
        .c_o   (cr_s[ch][s+1])
      );
    end
  end

  function automatic logic signed [15:0] to_q13(input cordic_t c, input int lim);
    logic signed [ZW:0] s;
    logic signed [ZW:0] r;
    logic signed [ZW:0] l;
    s = c.zero ? (ZW+1)'(64) : ((ZW+1)'(c.z) + (ZW+1)'(64));
    r = s >>> 7;
    l = (ZW+1)'(lim);
    if (r > l) r = l;
    if (r < -l) r = -l;
    return r[15:0];
  endfunction

  logic signed [15:0] roll_q, yaw_q, pitch_full;
  logic signed [14:0] pitch_q;
  logic clamp_q;
  cordic_t pe;
  assign pe         = cr_s[1][CORDIC_STEPS];
  assign pitch_full = pe.tag[0] ? (pe.tag[1] ? -16'(HALF_PI_Q13) : 16'(HALF_PI_Q13))
                                : to_q13(pe, HALF_PI_Q13);

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_q  <= to_q13(cr_s[0][CORDIC_STEPS], PI_Q13);
      yaw_q   <= to_q13(cr_s[2][CORDIC_STEPS], PI_Q13);
      pitch_q <= pitch_full[14:0];
      clamp_q <= pe.tag[0];
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {1'b0, yaw_q, pitch_q, roll_q};
  assign m_axis_tuser_o  = clamp_q;

`include "quaternion_to_euler_angles_assert.svh"

  `QTE_ASSERT(a_clamp_value, clk_i, rst_ni, !(m_valid_q && clamp_q) || (pitch_q == 15'sd12868) || (pitch_q == -15'sd12868))
  `QTE_ASSERT(a_roll_range, clk_i, rst_ni, !m_valid_q || ((roll_q <= 16'sd25736) && (roll_q >= -16'sd25736)))
  `QTE_ASSERT_NEXT(a_pipe_out, clk_i, rst_ni, vld_q[PIPE_LEN-1] && en, m_valid_q)
endmodule

>>> verif/quaternion_to_euler_angles_test.sv
// Self-checking bench for quaternion_to_euler_angles: random and corner quaternions,
// predicted angles checked against the output stream. Depends on the RTL top only.
module quaternion_to_euler_angles_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS = 16;
  localparam longint ONE_Q28 = 64'sd1 << 28;
  localparam longint HALF_PI_Z = 1647099;
  localparam int LAT = 35 + STEPS;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic        clamp;
    logic [15:0] yaw;
    logic [14:0] pitch;
    logic [15:0] roll;
  } angles_t;

  function automatic longint angle_step(input int i);
    longint t[24] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                      4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0};
    return t[i];
  endfunction

  function automatic longint atan2_q20(input longint yy, input longint xx);
    longint z, t, dx, dy;
    z = 0;
    if (xx == 0 && yy == 0) return 0;
    if (xx < 0) begin
      t = xx;
      if (yy >= 0) begin
        xx = yy; yy = -t; z = HALF_PI_Z;
      end else begin
        xx = -yy; yy = t; z = -HALF_PI_Z;
      end
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      dx = yy >>> i;
      dy = xx >>> i;
      if (yy >= 0) begin
        xx += dx; yy -= dy; z += angle_step(i);
      end else begin
        xx -= dx; yy += dy; z -= angle_step(i);
      end
    end
    return z;
  endfunction

  function automatic longint round_q13(input longint z, input longint lim);
    longint r;
    r = (z + 64) >>> 7;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic angles_t euler_of(input logic [63:0] q);
    longint w, x, y, z, sr, cr, sy, cy, sp, p;
    logic [63:0] mag;
    angles_t a;
    w = longint'($signed(q[15:0]));
    x = longint'($signed(q[31:16]));
    y = longint'($signed(q[47:32]));
    z = longint'($signed(q[63:48]));
    sr = 2 * (w * x + y * z);
    cr = ONE_Q28 - 2 * (x * x + y * y);
    sy = 2 * (w * z + x * y);
    cy = ONE_Q28 - 2 * (y * y + z * z);
    sp = 2 * (w * y - z * x);
    a.roll = 16'(round_q13(atan2_q20(sr, cr), 25736));
    a.yaw = 16'(round_q13(atan2_q20(sy, cy), 25736));
    if (sp >= ONE_Q28 || sp <= -ONE_Q28) begin
      a.clamp = 1'b1;
      p = (sp < 0) ? -12868 : 12868;
    end else begin
      a.clamp = 1'b0;
      mag = (sp < 0) ? -sp : sp;
      p = round_q13(atan2_q20(sp, longint'(root_floor((64'd1 << 56) - mag * mag))), 12868);
    end
    a.pitch = 15'(p);
    return a;
  endfunction

  class angle_scoreboard;
    angles_t pending[$];
    int errors;
    function void note_quat(logic [63:0] q);
      pending.push_back(euler_of(q));
    endfunction
    function void check_angles(logic [47:0] d, logic u);
      angles_t want, got;
      got = {u, d[46:0]};
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want || d[47] !== 1'b0) begin
        $display("%0t: mismatch expected roll %0d pitch %0d yaw %0d clamp %0b",
                 $realtime, $signed(want.roll), $signed(want.pitch),
                 $signed(want.yaw), want.clamp);
        $display("%0t:          actual roll %0d pitch %0d yaw %0d clamp %0b pad %0b",
                 $realtime, $signed(got.roll), $signed(got.pitch),
                 $signed(got.yaw), got.clamp, d[47]);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic s_axis_tvalid_i = 0, m_axis_tready_i = 0;
  logic [63:0] s_axis_tdata_i = '0;
  logic s_axis_tready_o, m_axis_tvalid_o, m_axis_tuser_o;
  logic [47:0] m_axis_tdata_o;

  quaternion_to_euler_angles #(.CORDIC_STEPS(STEPS)) uut (.*);

  angle_scoreboard board = new();
  int send_idle_pct = 0, recv_stall_pct = 0;
  bit hold_off = 0, stim_done = 0;
  int idle_cycles = 0;

  initial forever #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) board.note_quat(s_axis_tdata_i);
      if (m_axis_tvalid_o && m_axis_tready_i) board.check_angles(m_axis_tdata_o, m_axis_tuser_o);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      m_axis_tready_i <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_quat(input logic [63:0] q);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= q;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  function automatic logic [15:0] pick_comp();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'h4000;
      4: return 16'hc000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] unit_quat();
    real a, b, c, d, n;
    a = $itor($signed(16'($urandom)));
    b = $itor($signed(16'($urandom)));
    c = $itor($signed(16'($urandom)));
    d = $itor($signed(16'($urandom)));
    n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
    return {16'($rtoi(d / n * 16384.0)), 16'($rtoi(c / n * 16384.0)),
            16'($rtoi(b / n * 16384.0)), 16'($rtoi(a / n * 16384.0))};
  endfunction

  initial begin
    logic [63:0] corner[$];
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    corner = '{64'h0, {4{16'h4000}}, {4{16'h7fff}}, {4{16'h8000}},
               {48'h0, 16'h4000}, {16'h0, 16'h0, 16'h0, 16'hc000},
               {32'h0, 16'h2d41, 16'h2d41}, {32'h0, 16'hd2bf, 16'h2d41},
               {16'h0, 16'h2d41, 16'h0, 16'h2d41}, {16'h0, 16'hd2bf, 16'h0, 16'h2d41},
               {16'h2d41, 32'h0, 16'h2d41}, {16'h2000, 16'h2000, 16'h2000, 16'h2000},
               {16'hd2bf, 16'h0, 16'h2d41, 16'h0}, {16'h2d41, 16'h0, 16'h2d41, 16'h0},
               {16'h7fff, 16'h8000, 16'h7fff, 16'h8000}, {16'h0, 16'h4000, 32'h0},
               {16'h4000, 48'h0}, {16'h1000, 16'h0, 16'h0, 16'h1000}};
    foreach (corner[i]) send_quat(corner[i]);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 73 : 30) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 73 : 30) : 0;
      for (int n = 0; n < 420; n++) begin
        if (ph == 0 && n == 50) hold_off = 1;
        if (ph == 0 && n == 200) hold_off = 0;
        if ($urandom_range(3) == 0)
          send_quat({pick_comp(), pick_comp(), pick_comp(), pick_comp()});
        else
          send_quat(unit_quat());
      end
    end
    s_axis_tvalid_i <= 1'b0;
    stim_done = 1;
  end

  initial begin
    int hold_cycles;
    wait (hold_off);
    hold_cycles = 0;
    while (hold_off && hold_cycles < 300) begin
      @(posedge clk_i);
      hold_cycles++;
    end
    hold_off = 0;
  end

  initial begin
    wait (stim_done);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (LAT + 20) @(posedge clk_i);
    if (board.errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end
endmodule
